[design/lzhc_pkg.sv]
package lzhc_pkg;

    localparam int WINDOW_MAX   = 4096;
    localparam int LEN_MAX      = 256;
    localparam int WIN_MIN      = 16;
    localparam int LEN_MIN      = 4;
    localparam int HASH_W       = 14;
    localparam int HASH_ENTRIES = 1 << HASH_W;
    localparam int RING_DEPTH   = WINDOW_MAX + LEN_MAX;
    localparam int NEXT_DEPTH   = WINDOW_MAX + HASH_ENTRIES;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int NEXT_AW      = $clog2(NEXT_DEPTH);
    localparam int POS_W        = $clog2(WINDOW_MAX);
    localparam int WIN_W        = 13;
    localparam int LEN_W        = 9;
    localparam int PTR_W        = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [1:0] OP_PRELOAD   = 2'd0;
    localparam logic [1:0] OP_ADV_LINK  = 2'd1;
    localparam logic [1:0] OP_ADV_PLAIN = 2'd2;
    localparam logic [1:0] OP_SEARCH    = 2'd3;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_MAX_LEN     = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] match_length;
        logic [WIN_W-1:0] match_offset;
    } result_t;

    typedef enum logic [1:0] {
        K_PRELOAD,
        K_ADVANCE,
        K_SEARCH
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       link;
        logic [7:0] data;
    } q_item_t;

    typedef struct packed {
        logic             ok;
        logic [PTR_W-1:0] ptr;
    } link_t;

endpackage

[design/lzss_hash_chain_match_finder_top.sv]
// LZSS longest-match finder over a ring window with hash chains.
// Input beats (item_valid/item_ready) carry an operation and a byte:
// preload a lookahead byte, advance with or without linking the current
// position, or search. Only a search returns a beat on result_valid /
// result_ready: best match length and backward offset, both zero when none.
// Beats enter a four-deep queue; a sequencer behind it owns the window,
// next-link and prev-link memories and runs one item at a time.
// A search walks its hash chain, so how long it takes is set by the chain
// length and the single window-memory port.
// The APB port holds window_size (address 0) and max_len (address 4).
// After reset, and after every register write, the link memories are
// swept clear one entry a cycle, with item_ready low.
// Write registers only while the block is idle. A stalled result is held
// in the output register; the queue keeps taking beats until it fills.
module lzss_hash_chain_match_finder_top
    import lzhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [WIN_W-1:0] window_size_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic [WIN_W-1:0] eff_win;
    logic [LEN_W-1:0] eff_len;
    logic             cfg_write;
    logic             clearing;
    logic             q_valid;
    logic             q_pop;
    q_item_t          q_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW_SIZE: prdata = PDATA_W'(window_size_reg);
            REG_MAX_LEN:     prdata = PDATA_W'(max_len_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (window_size_reg < WIN_W'(WIN_MIN))
        begin
            eff_win = WIN_W'(WIN_MIN);
        end
        else if (window_size_reg > WIN_W'(WINDOW_MAX))
        begin
            eff_win = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_win = window_size_reg;
        end
        if (max_len_reg < LEN_W'(LEN_MIN))
        begin
            eff_len = LEN_W'(LEN_MIN);
        end
        else if (max_len_reg > LEN_W'(LEN_MAX))
        begin
            eff_len = LEN_W'(LEN_MAX);
        end
        else
        begin
            eff_len = max_len_reg;
        end
        if (eff_win < {eff_len[LEN_W-2:0], 1'b0} || eff_len[LEN_W-1] && eff_win < WIN_W'(512))
        begin
            eff_len = LEN_W'((eff_win >> 1) - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(WINDOW_MAX);
            max_len_reg     <= LEN_W'(18);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_WINDOW_SIZE: window_size_reg <= pwdata[WIN_W-1:0];
                REG_MAX_LEN:     max_len_reg     <= pwdata[LEN_W-1:0];
                default:         max_len_reg     <= max_len_reg;
            endcase
        end
    end

    lzhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    lzhc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .init_req (cfg_write),
        .eff_win  (eff_win),
        .eff_len  (eff_len),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .res_valid(result_valid),
        .res_ready(result_ready),
        .res      (result)
    );

endmodule

[design/lzhc_ram.sv]
module lzhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[design/lzhc_front.sv]
module lzhc_front
    import lzhc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    input  logic    clearing,
    output logic    q_valid,
    output q_item_t q_item,
    input  logic    q_pop
);

    q_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    q_item_t             cls;
    logic                push;
    logic                pop;

    // classify the beat before queueing it
    always_comb
    begin
        cls.data = item.data_byte;
        cls.link = (item.operation == OP_ADV_LINK);
        case (item.operation)
            OP_PRELOAD:   cls.kind = K_PRELOAD;
            OP_ADV_LINK:  cls.kind = K_ADVANCE;
            OP_ADV_PLAIN: cls.kind = K_ADVANCE;
            OP_SEARCH:    cls.kind = K_SEARCH;
            default:      cls.kind = K_SEARCH;
        endcase
    end

    assign item_ready = !clearing && (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign q_item     = slot_reg[rd_ptr_reg];
    assign pop        = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/lzhc_back.sv]
module lzhc_back
    import lzhc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             init_req,
    input  logic [WIN_W-1:0] eff_win,
    input  logic [LEN_W-1:0] eff_len,
    input  logic             q_valid,
    input  q_item_t          q_item,
    output logic             q_pop,
    output logic             clearing,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_PRE_W2,
        ST_U0, ST_U1, ST_U2, ST_U3,
        ST_ADV_W1, ST_ADV_W2, ST_ADV_NX, ST_ADV_END,
        ST_LK_H, ST_H_RD, ST_H_CAP, ST_L_RD, ST_L_W1, ST_L_W2,
        ST_S_HEAD, ST_S_NXT, ST_C_A, ST_C_B, ST_C_C, ST_EVAL, ST_CONT, ST_S_OUT
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    state_t             hret_reg, hret_next;
    logic [NEXT_AW-1:0] clr_reg, clr_next;
    logic [POS_W-1:0]   ins_reg, ins_next;
    logic [POS_W-1:0]   del_reg, del_next;
    logic [LEN_W-1:0]   pre_reg, pre_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [NEXT_AW-1:0] d_reg, d_next;
    logic [PTR_W-1:0]   nl_reg, nl_next;
    logic [NEXT_AW-1:0] head_reg, head_next;
    logic               had_reg, had_next;
    logic [PTR_W-1:0]   old_reg, old_next;
    logic [HASH_W-1:0]  h_reg, h_next;
    logic [1:0]         hk_reg, hk_next;
    logic [NEXT_AW-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [7:0]         a_reg, a_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   bst_len_reg, bst_len_next;
    logic [WIN_W-1:0]   bst_ofs_reg, bst_ofs_next;
    logic [WIN_W-1:0]   steps_reg, steps_next;
    logic [7:0]         byte_reg, byte_next;
    logic               link_reg, link_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               win_we;
    logic [RING_AW-1:0] win_addr;
    logic [7:0]         win_wdata, win_rdata;
    logic               nxt_we;
    logic [NEXT_AW-1:0] nxt_addr;
    link_t              nxt_wdata, nxt_rdata;
    logic               prv_we;
    logic [POS_W-1:0]   prv_addr;
    link_t              prv_wdata, prv_rdata;

    logic [WIN_W-1:0]   pre_sum;
    logic [POS_W-1:0]   pre_pos;
    logic [WIN_W-1:0]   ofs;
    logic [WIN_W-1:0]   cap_len;
    logic               keep_old;

    lzhc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_win (
        .clk(clk), .we(win_we), .addr(win_addr), .wdata(win_wdata), .rdata(win_rdata)
    );

    lzhc_ram #(.WIDTH($bits(link_t)), .DEPTH(NEXT_DEPTH)) u_nxt (
        .clk(clk), .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wdata), .rdata(nxt_rdata)
    );

    lzhc_ram #(.WIDTH($bits(link_t)), .DEPTH(WINDOW_MAX)) u_prv (
        .clk(clk), .we(prv_we), .addr(prv_addr), .wdata(prv_wdata), .rdata(prv_rdata)
    );

    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        pre_sum = WIN_W'(ins_reg) + WIN_W'(pre_reg);
        if (pre_sum >= eff_win)
        begin
            pre_sum = pre_sum - eff_win;
        end
        pre_pos = pre_sum[POS_W-1:0];

        // backward distance from the lookahead to the chain entry
        if (ins_reg <= cur_reg[POS_W-1:0])
        begin
            ofs = eff_win + WIN_W'(ins_reg) - WIN_W'(cur_reg[POS_W-1:0]);
        end
        else
        begin
            ofs = WIN_W'(ins_reg) - WIN_W'(cur_reg[POS_W-1:0]);
        end
        cap_len  = (ofs <= WIN_W'(len_reg)) ? ofs : WIN_W'(len_reg);
        keep_old = (len_reg <= bst_len_reg)
                || ((ofs <= WIN_W'(len_reg)) && (ofs <= WIN_W'(bst_len_reg)));
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        hret_next      = hret_reg;
        clr_next       = clr_reg;
        ins_next       = ins_reg;
        del_next       = del_reg;
        pre_next       = pre_reg;
        pos_next       = pos_reg;
        d_next         = d_reg;
        nl_next        = nl_reg;
        head_next      = head_reg;
        had_next       = had_reg;
        old_next       = old_reg;
        h_next         = h_reg;
        hk_next        = hk_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        len_next       = len_reg;
        bst_len_next   = bst_len_reg;
        bst_ofs_next   = bst_ofs_reg;
        steps_next     = steps_reg;
        byte_next      = byte_reg;
        link_next      = link_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        win_we         = 1'b0;
        win_addr       = '0;
        win_wdata      = byte_reg;
        nxt_we         = 1'b0;
        nxt_addr       = '0;
        nxt_wdata      = '0;
        prv_we         = 1'b0;
        prv_addr       = '0;
        prv_wdata      = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                nxt_we   = 1'b1;
                nxt_addr = clr_reg;
                prv_we   = (clr_reg < NEXT_AW'(WINDOW_MAX));
                prv_addr = clr_reg[POS_W-1:0];
                if (clr_reg == NEXT_AW'(NEXT_DEPTH - 1))
                begin
                    ins_next   = POS_W'(eff_win - WIN_W'(eff_len));
                    del_next   = '0;
                    pre_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    byte_next = q_item.data;
                    link_next = q_item.link;
                    case (q_item.kind)
                        K_PRELOAD:
                        begin
                            if (pre_reg < eff_len)
                            begin
                                win_we    = 1'b1;
                                win_addr  = RING_AW'(pre_pos);
                                win_wdata = q_item.data;
                                pre_next  = pre_reg + 1'b1;
                                if (LEN_W'(pre_pos) < eff_len && pre_pos < POS_W'(LEN_MAX))
                                begin
                                    pos_next   = pre_pos;
                                    state_next = ST_PRE_W2;
                                end
                            end
                        end
                        K_ADVANCE:
                        begin
                            pos_next   = del_reg;
                            ret_next   = ST_ADV_W1;
                            state_next = ST_U0;
                        end
                        K_SEARCH:
                        begin
                            pos_next     = ins_reg;
                            hk_next      = '0;
                            h_next       = '0;
                            hret_next    = ST_S_HEAD;
                            bst_len_next = '0;
                            bst_ofs_next = '0;
                            state_next   = ST_H_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRE_W2:
            begin
                // mirror the byte past the ring end
                win_we     = 1'b1;
                win_addr   = RING_AW'(pos_reg) + RING_AW'(eff_win);
                state_next = ST_IDLE;
            end
            ST_U0:
            begin
                prv_addr   = pos_reg;
                state_next = ST_U1;
            end
            ST_U1:
            begin
                if (!prv_rdata.ok)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    d_next     = prv_rdata.ptr[NEXT_AW-1:0];
                    prv_we     = 1'b1;
                    prv_addr   = pos_reg;
                    nxt_addr   = NEXT_AW'(pos_reg);
                    state_next = ST_U2;
                end
            end
            ST_U2:
            begin
                nxt_we    = 1'b1;
                nxt_addr  = d_reg;
                nxt_wdata = nxt_rdata;
                nl_next   = nxt_rdata.ptr;
                state_next = nxt_rdata.ok ? ST_U3 : ret_reg;
            end
            ST_U3:
            begin
                nxt_we    = 1'b1;
                nxt_addr  = NEXT_AW'(pos_reg);
                if (nl_reg < PTR_W'(WINDOW_MAX))
                begin
                    prv_we    = 1'b1;
                    prv_addr  = nl_reg[POS_W-1:0];
                    prv_wdata = '{ok: 1'b1, ptr: PTR_W'(d_reg)};
                end
                state_next = ret_reg;
            end
            ST_ADV_W1:
            begin
                win_we   = 1'b1;
                win_addr = RING_AW'(del_reg);
                if (LEN_W'(del_reg) < eff_len && del_reg < POS_W'(LEN_MAX))
                begin
                    state_next = ST_ADV_W2;
                end
                else
                begin
                    state_next = ST_ADV_NX;
                end
            end
            ST_ADV_W2:
            begin
                win_we     = 1'b1;
                win_addr   = RING_AW'(del_reg) + RING_AW'(eff_win);
                state_next = ST_ADV_NX;
            end
            ST_ADV_NX:
            begin
                if (WIN_W'(del_reg) + 1'b1 >= eff_win)
                begin
                    del_next = '0;
                end
                else
                begin
                    del_next = del_reg + 1'b1;
                end
                if (link_reg)
                begin
                    pos_next   = ins_reg;
                    ret_next   = ST_LK_H;
                    state_next = ST_U0;
                end
                else
                begin
                    state_next = ST_ADV_END;
                end
            end
            ST_LK_H:
            begin
                hk_next    = '0;
                h_next     = '0;
                hret_next  = ST_L_RD;
                state_next = ST_H_RD;
            end
            ST_H_RD:
            begin
                win_addr   = RING_AW'(pos_reg) + RING_AW'(hk_reg);
                state_next = ST_H_CAP;
            end
            ST_H_CAP:
            begin
                h_next = h_reg ^ (HASH_W'(win_rdata) << {hk_reg, 1'b0});
                if (hk_reg == 2'd3)
                begin
                    state_next = hret_reg;
                end
                else
                begin
                    hk_next    = hk_reg + 1'b1;
                    state_next = ST_H_RD;
                end
            end
            ST_L_RD:
            begin
                head_next  = NEXT_AW'(eff_win) + NEXT_AW'(h_reg);
                nxt_addr   = NEXT_AW'(eff_win) + NEXT_AW'(h_reg);
                state_next = ST_L_W1;
            end
            ST_L_W1:
            begin
                had_next   = nxt_rdata.ok;
                old_next   = nxt_rdata.ptr;
                nxt_we     = 1'b1;
                nxt_addr   = head_reg;
                nxt_wdata  = '{ok: 1'b1, ptr: PTR_W'(pos_reg)};
                prv_we     = 1'b1;
                prv_addr   = pos_reg;
                prv_wdata  = '{ok: 1'b1, ptr: PTR_W'(head_reg)};
                state_next = ST_L_W2;
            end
            ST_L_W2:
            begin
                nxt_we   = 1'b1;
                nxt_addr = NEXT_AW'(pos_reg);
                if (had_reg && old_reg < PTR_W'(WINDOW_MAX))
                begin
                    nxt_wdata = '{ok: 1'b1, ptr: old_reg};
                    prv_we    = 1'b1;
                    prv_addr  = old_reg[POS_W-1:0];
                    prv_wdata = '{ok: 1'b1, ptr: PTR_W'(pos_reg)};
                end
                state_next = ST_ADV_END;
            end
            ST_ADV_END:
            begin
                if (WIN_W'(ins_reg) + 1'b1 >= eff_win)
                begin
                    ins_next = '0;
                end
                else
                begin
                    ins_next = ins_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_S_HEAD:
            begin
                nxt_addr   = NEXT_AW'(eff_win) + NEXT_AW'(h_reg);
                steps_next = '0;
                state_next = ST_S_NXT;
            end
            ST_S_NXT:
            begin
                if (!nxt_rdata.ok || nxt_rdata.ptr >= PTR_W'(WINDOW_MAX))
                begin
                    state_next = ST_S_OUT;
                end
                else
                begin
                    cur_next   = nxt_rdata.ptr[NEXT_AW-1:0];
                    k_next     = '0;
                    state_next = ST_C_A;
                end
            end
            ST_C_A:
            begin
                win_addr   = RING_AW'(cur_reg[POS_W-1:0]) + RING_AW'(k_reg);
                state_next = ST_C_B;
            end
            ST_C_B:
            begin
                a_next     = win_rdata;
                win_addr   = RING_AW'(ins_reg) + RING_AW'(k_reg);
                state_next = ST_C_C;
            end
            ST_C_C:
            begin
                if (win_rdata == a_reg)
                begin
                    if (k_reg + 1'b1 == eff_len)
                    begin
                        len_next   = eff_len;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_C_A;
                    end
                end
                else if (k_reg < LEN_W'(LEN_MIN))
                begin
                    state_next = ST_CONT;
                end
                else
                begin
                    len_next   = k_reg;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (keep_old)
                begin
                    state_next = ST_CONT;
                end
                else
                begin
                    bst_ofs_next = ofs;
                    if (cap_len >= WIN_W'(eff_len))
                    begin
                        // full-length hit: drop the entry and stop walking
                        bst_len_next = eff_len;
                        pos_next     = cur_reg[POS_W-1:0];
                        ret_next     = ST_S_OUT;
                        state_next   = ST_U0;
                    end
                    else
                    begin
                        bst_len_next = LEN_W'(cap_len);
                        state_next   = ST_CONT;
                    end
                end
            end
            ST_CONT:
            begin
                if (steps_reg + 1'b1 >= eff_win)
                begin
                    state_next = ST_S_OUT;
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    nxt_addr   = cur_reg;
                    state_next = ST_S_NXT;
                end
            end
            ST_S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.match_length = bst_len_reg;
                    res_next.match_offset = bst_ofs_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (init_req)
        begin
            state_next     = ST_CLEAR;
            clr_next       = '0;
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_IDLE;
            hret_reg      <= ST_IDLE;
            clr_reg       <= '0;
            ins_reg       <= '0;
            del_reg       <= '0;
            pre_reg       <= '0;
            hk_reg        <= '0;
            k_reg         <= '0;
            steps_reg     <= '0;
            link_reg      <= 1'b0;
            had_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            hret_reg      <= hret_next;
            clr_reg       <= clr_next;
            ins_reg       <= ins_next;
            del_reg       <= del_next;
            pre_reg       <= pre_next;
            hk_reg        <= hk_next;
            k_reg         <= k_next;
            steps_reg     <= steps_next;
            link_reg      <= link_next;
            had_reg       <= had_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        d_reg       <= d_next;
        nl_reg      <= nl_next;
        head_reg    <= head_next;
        old_reg     <= old_next;
        h_reg       <= h_next;
        cur_reg     <= cur_next;
        a_reg       <= a_next;
        len_reg     <= len_next;
        bst_len_reg <= bst_len_next;
        bst_ofs_reg <= bst_ofs_next;
        byte_reg    <= byte_next;
        res_reg     <= res_next;
    end

endmodule

[design/lzhc_checker.sv]
module lzhc_checker
    import lzhc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.match_length == '0) == (result.match_offset == '0)))
        else $error("match length and offset disagree on no-match");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.match_length <= LEN_W'(LEN_MAX))
                      && (result.match_offset <= WIN_W'(WINDOW_MAX)))
        else $error("match out of range");

    a_len_le_ofs: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (WIN_W'(result.match_length) <= result.match_offset))
        else $error("match length exceeds its offset");

endmodule

bind lzss_hash_chain_match_finder_top lzhc_checker u_lzhc_checker (.*);

[test/lzss_hash_chain_match_finder_checker.sv]
`timescale 1ns / 1ps

module lzss_hash_chain_match_finder_checker
    import lzhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending,
    output int                 items_seen,
    output int                 results_seen
);

    int unsigned cfg_window;
    int unsigned cfg_maxlen;
    int unsigned win_len;
    int unsigned run_len;

    bit [7:0]    ring [RING_DEPTH];
    int unsigned nxt_ptr [NEXT_DEPTH];
    bit          nxt_ok [NEXT_DEPTH];
    int unsigned prv_ptr [WINDOW_MAX];
    bit          prv_ok [WINDOW_MAX];
    int unsigned ins_pos;
    int unsigned del_pos;
    int unsigned pre_cnt;

    result_t     match_q [$];

    function automatic int unsigned rd_byte(int unsigned i);
        return (i < RING_DEPTH) ? ring[i] : 0;
    endfunction

    // mirror the head of the ring past its end so reads never wrap
    function automatic void store_byte(int unsigned pos, bit [7:0] b);
        if (pos < RING_DEPTH)
            ring[pos] = b;
        if (pos < run_len && pos + win_len < RING_DEPTH)
            ring[pos + win_len] = b;
    endfunction

    function automatic int unsigned hash4(int unsigned p);
        return (rd_byte(p) ^ (rd_byte(p + 1) << 2) ^ (rd_byte(p + 2) << 4)
                ^ (rd_byte(p + 3) << 6)) & (HASH_ENTRIES - 1);
    endfunction

    function automatic void chain_unlink(int unsigned pos);
        int unsigned d;
        int unsigned s;
        if (pos >= WINDOW_MAX || !prv_ok[pos])
            return;
        d = prv_ptr[pos];
        prv_ok[pos] = 0;
        if (d >= NEXT_DEPTH)
            return;
        nxt_ptr[d] = nxt_ptr[pos];
        nxt_ok[d] = nxt_ok[pos];
        if (!nxt_ok[pos])
            return;
        s = nxt_ptr[pos];
        nxt_ok[pos] = 0;
        if (s < WINDOW_MAX)
        begin
            prv_ptr[s] = d;
            prv_ok[s] = 1;
        end
    endfunction

    function automatic void chain_link(int unsigned p);
        int unsigned head;
        int unsigned old;
        bit          had;
        if (p >= WINDOW_MAX)
            return;
        chain_unlink(p);
        head = win_len + hash4(p);
        old = nxt_ptr[head];
        had = nxt_ok[head];
        nxt_ptr[head] = p;
        nxt_ok[head] = 1;
        prv_ptr[p] = head;
        prv_ok[p] = 1;
        nxt_ok[p] = 0;
        if (had && old < WINDOW_MAX)
        begin
            prv_ptr[old] = p;
            prv_ok[old] = 1;
            nxt_ptr[p] = old;
            nxt_ok[p] = 1;
        end
    endfunction

    function automatic void clear_window();
        win_len = cfg_window;
        if (win_len < WIN_MIN) win_len = WIN_MIN;
        if (win_len > WINDOW_MAX) win_len = WINDOW_MAX;
        run_len = cfg_maxlen;
        if (run_len < LEN_MIN) run_len = LEN_MIN;
        if (run_len > LEN_MAX) run_len = LEN_MAX;
        if (win_len < 2 * run_len) run_len = (win_len >> 1) - 1;
        foreach (ring[i]) ring[i] = 0;
        foreach (nxt_ok[i])
        begin
            nxt_ok[i] = 0;
            nxt_ptr[i] = 0;
        end
        foreach (prv_ok[i])
        begin
            prv_ok[i] = 0;
            prv_ptr[i] = 0;
        end
        ins_pos = win_len - run_len;
        del_pos = 0;
        pre_cnt = 0;
    endfunction

    function automatic result_t longest_match();
        int unsigned rp;
        int unsigned cur;
        int unsigned k;
        int unsigned len;
        int unsigned ofs;
        int unsigned best_len;
        int unsigned best_ofs;
        result_t     r;
        best_len = 0;
        best_ofs = 0;
        rp = ins_pos;
        cur = win_len + hash4(rp);
        for (int unsigned n = 0; n < win_len; n++)
        begin
            if (cur >= NEXT_DEPTH || !nxt_ok[cur])
                break;
            cur = nxt_ptr[cur];
            if (cur >= WINDOW_MAX)
                break;
            for (k = 0; k < 4; k++)
                if (rd_byte(cur + k) != rd_byte(rp + k))
                    break;
            if (k < 4)
                continue;
            len = 4;
            while (len < run_len && rd_byte(cur + len) == rd_byte(rp + len))
                len++;
            if (len <= best_len)
                continue;
            ofs = (rp <= cur) ? win_len + rp - cur : rp - cur;
            // a match cannot run past its own offset
            if (ofs <= len)
            begin
                if (ofs <= best_len)
                    continue;
                len = ofs;
            end
            best_ofs = ofs;
            best_len = len;
            if (best_len >= run_len)
            begin
                chain_unlink(cur);
                best_len = run_len;
                break;
            end
        end
        r.match_length = best_len[LEN_W-1:0];
        r.match_offset = best_ofs[WIN_W-1:0];
        return r;
    endfunction

    function automatic void apply_item(item_t it);
        int unsigned p;
        case (it.operation)
            OP_PRELOAD:
            begin
                if (pre_cnt < run_len)
                begin
                    p = ins_pos + pre_cnt;
                    if (p >= win_len) p -= win_len;
                    store_byte(p, it.data_byte);
                    pre_cnt++;
                end
            end
            OP_ADV_LINK, OP_ADV_PLAIN:
            begin
                chain_unlink(del_pos);
                store_byte(del_pos, it.data_byte);
                del_pos++;
                if (del_pos >= win_len) del_pos = 0;
                if (it.operation == OP_ADV_LINK)
                    chain_link(ins_pos);
                ins_pos++;
                if (ins_pos >= win_len) ins_pos = 0;
            end
            default:
                match_q.push_back(longest_match());
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window = WINDOW_MAX;
            cfg_maxlen = 18;
            clear_window();
            match_q.delete();
            fail_count = 0;
            items_seen = 0;
            results_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE)
                    cfg_window = pwdata[WIN_W-1:0];
                else
                    cfg_maxlen = pwdata[LEN_W-1:0];
                clear_window();
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (match_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing expected: len %0d ofs %0d",
                                 $realtime, result.match_length, result.match_offset);
                end
                else
                begin
                    result_t exp_r;
                    exp_r = match_q.pop_front();
                    if (exp_r.match_length !== result.match_length ||
                        exp_r.match_offset !== result.match_offset)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: exp len %0d ofs %0d, got len %0d ofs %0d",
                                     $realtime, exp_r.match_length, exp_r.match_offset,
                                     result.match_length, result.match_offset);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                items_seen++;
                apply_item(item);
            end
        end
        pending = match_q.size();
    end

endmodule

[test/lzss_hash_chain_match_finder_top_test.sv]
`timescale 1ns / 1ps

module lzss_hash_chain_match_finder_top_test
    import lzhc_pkg::*;
();

    // a full walk of the longest chain at full match length, with margin
    localparam int STALL_LIMIT = 4 * WINDOW_MAX * (3 * LEN_MAX + 8);

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int idle_cycles;
    int settings_run;
    bit hold_req;
    bit hold_done;

    lzss_hash_chain_match_finder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    lzss_hash_chain_match_finder_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .results_seen (results_seen)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // watchdog: a search may walk a long chain with nothing accepted meanwhile
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold once searches flow
    initial
    begin
        int n;
        result_ready = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done && pending != 0)
            begin
                result_ready = 0;
                repeat (3000) @(negedge clk);
                hold_done = 1;
            end
            else if ($urandom_range(0, 9) < 6)
            begin
                result_ready = 1;
                n = $urandom_range(1, 20);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                result_ready = 0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic apb_write(logic reg_idx, int unsigned value);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        // let the link sweep finish before anything else
        @(negedge clk);
        while (!item_ready) @(negedge clk);
    endtask

    task automatic send_beat(logic [1:0] op, logic [7:0] b);
        int gap;
        item_valid = 1;
        item.operation = op;
        item.data_byte = b;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
        gap = $urandom_range(0, 99);
        if (gap >= 70)
        begin
            item_valid = 0;
            gap = (gap >= 95) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        item_valid = 0;
        while (pending != 0) @(negedge clk);
        // non-search beats may still be in the queue
        repeat (300) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte(int alpha);
        if (alpha == 0)
            return 8'($urandom_range(0, 255));
        return 8'h41 + 8'($urandom_range(0, alpha - 1));
    endfunction

    task automatic fill_lookahead(int unsigned win, int unsigned ml, int alpha);
        int unsigned w;
        int unsigned e;
        w = (win < WIN_MIN) ? WIN_MIN : (win > WINDOW_MAX) ? WINDOW_MAX : win;
        e = (ml < LEN_MIN) ? LEN_MIN : (ml > LEN_MAX) ? LEN_MAX : ml;
        if (w < 2 * e) e = (w >> 1) - 1;
        // a few surplus bytes: a full lookahead ignores them
        repeat (e + 3) send_beat(OP_PRELOAD, pick_byte(alpha));
    endtask

    task automatic random_phase(int unsigned win, int unsigned ml, int count, bit pause_mid);
        int alpha;
        int r;
        apb_write(REG_WINDOW_SIZE, win);
        apb_write(REG_MAX_LEN, ml);
        settings_run++;
        alpha = 4;
        fill_lookahead(win, ml, alpha);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                r = $urandom_range(0, 9);
                alpha = (r < 2) ? 1 : (r < 4) ? 2 : (r < 8) ? 4 : 0;
            end
            if (pause_mid && i == count / 2)
                drain();
            r = $urandom_range(0, 99);
            if (r < 50)
                send_beat(OP_ADV_LINK, pick_byte(alpha));
            else if (r < 65)
                send_beat(OP_ADV_PLAIN, pick_byte(alpha));
            else if (r < 97)
                send_beat(OP_SEARCH, 8'($urandom_range(0, 255)));
            else
                send_beat(OP_PRELOAD, 8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        item_valid = 0;
        item = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_req = 0;
        idle_cycles = 0;
        settings_run = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        while (!item_ready) @(negedge clk);

        // directed: reset settings, repeating pattern, empty chain, extremes
        for (int i = 0; i < 18; i++)
            send_beat(OP_PRELOAD, (i % 4 == 0) ? 8'hFF : (i % 4 == 1) ? 8'h00
                                                       : 8'(8'h41 + i % 4));
        send_beat(OP_SEARCH, 8'hFF);
        for (int i = 0; i < 6; i++)
            send_beat(OP_ADV_LINK, (i % 2) ? 8'hFF : 8'h00);
        send_beat(OP_SEARCH, 8'h00);
        send_beat(OP_ADV_PLAIN, 8'h42);
        send_beat(OP_ADV_LINK, 8'h43);
        send_beat(OP_SEARCH, 8'h00);
        send_beat(OP_PRELOAD, 8'h55);
        drain();

        random_phase(16, 4, 230, 0);
        hold_req = 1;
        random_phase(4096, 256, 220, 0);
        random_phase(0, 511, 200, 0);
        random_phase(8191, 0, 200, 0);
        random_phase(100, 60, 240, 1);
        random_phase(4000, 18, 220, 0);

        $display("Ran %0d input beats over %0d register settings, %0d search results checked",
                 items_seen, settings_run, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/lzhc_pkg.sv
design/lzhc_ram.sv
design/lzhc_front.sv
design/lzhc_back.sv
design/lzss_hash_chain_match_finder_top.sv
design/lzhc_checker.sv
test/lzss_hash_chain_match_finder_checker.sv
test/lzss_hash_chain_match_finder_top_test.sv
